// ===== design/psc_pkg.sv =====
// Shared constants and types for the palindromic substring counter.
`timescale 1ns / 1ps

package psc_pkg;

  localparam int unsigned MAX_LEN_DEF = 1024;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned TOTAL_W     = 20;
  localparam int unsigned ENDING_W    = 11;

  // Status of the list walker as seen by the control sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } walk_stat_t;

endpackage

// ===== design/psc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module psc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/psc_walk.sv =====
// List walker: extends the previous start list into the new one, one entry per cycle.
`timescale 1ns / 1ps

module psc_walk #(
  parameter int unsigned MAX_LEN = psc_pkg::MAX_LEN_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]                 len_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]                 pos_i,
  input  logic [psc_pkg::BYTE_W-1:0]                   ch_i,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] old_raddr_o,
  input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] old_rdata_i,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] text_raddr_o,
  input  logic [psc_pkg::BYTE_W-1:0]                   text_rdata_i,
  output logic                                         new_we_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] new_waddr_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] new_wdata_o,
  output logic [$clog2(MAX_LEN+1)-1:0]                 count_o,
  output psc_pkg::walk_stat_t                          stat_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {
    W_IDLE,
    W_RUN,
    W_DRAIN
  } wstate_e;

  wstate_e        state_q;
  logic [CW-1:0]  k_q;
  logic [CW-1:0]  count_q;
  logic           vb_q;
  logic           inj_q;
  logic           vc_q;
  logic           done_q;
  logic [AW-1:0]  cand_q;
  logic [AW-1:0]  start_pos;
  logic           hit;
  logic           final_wr;

  // Stage B: the candidate start is either a listed start or, for the
  // injected last entry, the current position (covers the p-1 check).
  always_comb begin
    start_pos    = inj_q ? pos_i[AW-1:0] : old_rdata_i;
    text_raddr_o = start_pos - AW'(1);
    old_raddr_o  = k_q[AW-1:0];
    hit          = vc_q && (text_rdata_i == ch_i);
    final_wr     = (state_q == W_DRAIN) && !vb_q && !vc_q;
    new_we_o     = hit || final_wr;
    new_waddr_o  = count_q[AW-1:0];
    new_wdata_o  = final_wr ? pos_i[AW-1:0] : cand_q;
    count_o      = count_q;
    stat_o.busy  = (state_q != W_IDLE);
    stat_o.done  = done_q;
  end

  always_ff @(posedge clk_i) begin
    cand_q <= start_pos - AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      k_q     <= '0;
      count_q <= '0;
      vb_q    <= 1'b0;
      inj_q   <= 1'b0;
      vc_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      vb_q   <= (state_q == W_RUN);
      inj_q  <= (state_q == W_RUN) && (k_q == len_i);
      vc_q   <= vb_q && (start_pos != '0);
      if (new_we_o) begin
        count_q <= count_q + CW'(1);
      end
      unique case (state_q)
        W_IDLE: begin
          if (start_i) begin
            k_q     <= '0;
            count_q <= '0;
            state_q <= W_RUN;
          end
        end
        W_RUN: begin
          if (k_q == len_i) begin
            state_q <= W_DRAIN;
          end else begin
            k_q <= k_q + CW'(1);
          end
        end
        W_DRAIN: begin
          if (final_wr) begin
            done_q  <= 1'b1;
            state_q <= W_IDLE;
          end
        end
        default: state_q <= W_IDLE;
      endcase
    end
  end

endmodule

// ===== design/palindromic_substring_counter_core.sv =====
// Top level of the palindromic substring counter: control, state and stores.
`timescale 1ns / 1ps

// The block counts the palindromic substrings of a string that arrives one
// byte per transfer; first_byte_i starts a new string, and reset also leaves
// an empty one. Each input transfer produces exactly one output transfer with
// the running count, the number of palindromes ending at this byte, and an
// overflow flag for a byte that arrived after MAX_LEN bytes and was dropped.
// A stored byte is handled by the list walker, which reads one start entry
// per cycle from the previous-list RAM and checks it against the text RAM
// read port; it walks the L entries of the previous list, where L is the
// number of palindromes that ended at the previous byte (at most the string
// length so far), plus one injected entry for the current position.
// A dropped byte skips the walk and goes straight to the result stage.
// The input is ready only while the block is idle; a finished result
// waits in an output register, so a new byte can be taken before the
// previous result has been collected. No clearing pass is needed after
// reset: the stores are only read at entries written earlier in the
// same string.
module palindromic_substring_counter_core #(
  parameter int unsigned MAX_LEN = psc_pkg::MAX_LEN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [psc_pkg::BYTE_W-1:0]     text_byte_i,
  input  logic                           first_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [psc_pkg::TOTAL_W-1:0]    total_count_o,
  output logic [psc_pkg::ENDING_W-1:0]   ending_here_o,
  output logic                           overflow_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_e;

  state_e                        state_q;
  logic [CW-1:0]                 pos_q;
  logic [CW-1:0]                 len_q;
  logic [psc_pkg::TOTAL_W-1:0]   total_q;
  logic                          bank_q;
  logic                          ovf_q;
  logic                          start_q;
  logic [psc_pkg::BYTE_W-1:0]    ch_q;

  logic                          in_fire;
  logic [CW-1:0]                 pos_eff;
  logic [CW-1:0]                 len_eff;
  logic [psc_pkg::TOTAL_W-1:0]   total_eff;
  logic                          too_long;

  logic [AW-1:0]                 old_raddr;
  logic [AW-1:0]                 rdata0;
  logic [AW-1:0]                 rdata1;
  logic [AW-1:0]                 old_rdata;
  logic [AW-1:0]                 text_raddr;
  logic [psc_pkg::BYTE_W-1:0]    text_rdata;
  logic                          new_we;
  logic [AW-1:0]                 new_waddr;
  logic [AW-1:0]                 new_wdata;
  logic [CW-1:0]                 walk_count;
  psc_pkg::walk_stat_t           walk_stat;

  // A new string clears position, list length and total before the byte
  // is used; the byte is dropped once the string already holds MAX_LEN bytes.
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    in_fire    = in_valid_i && in_ready_o;
    pos_eff    = first_byte_i ? '0 : pos_q;
    len_eff    = first_byte_i ? '0 : len_q;
    total_eff  = first_byte_i ? '0 : total_q;
    too_long   = (pos_eff >= CW'(MAX_LEN));
    old_rdata  = bank_q ? rdata1 : rdata0;
  end

  // The byte store is written at the transfer itself.
  psc_ram #(
    .WIDTH (psc_pkg::BYTE_W),
    .DEPTH (MAX_LEN)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && !too_long),
    .waddr_i (pos_eff[AW-1:0]),
    .wdata_i (text_byte_i),
    .raddr_i (text_raddr),
    .rdata_o (text_rdata)
  );

  // Two start-list banks: bank_q selects the previous list, and the new
  // list is built in the other one, so the copy becomes a bank swap.
  psc_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_LEN)
  ) u_list0_ram (
    .clk_i   (clk_i),
    .we_i    (new_we && bank_q),
    .waddr_i (new_waddr),
    .wdata_i (new_wdata),
    .raddr_i (old_raddr),
    .rdata_o (rdata0)
  );

  psc_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_LEN)
  ) u_list1_ram (
    .clk_i   (clk_i),
    .we_i    (new_we && !bank_q),
    .waddr_i (new_waddr),
    .wdata_i (new_wdata),
    .raddr_i (old_raddr),
    .rdata_o (rdata1)
  );

  psc_walk #(
    .MAX_LEN (MAX_LEN)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_q),
    .len_i        (len_q),
    .pos_i        (pos_q),
    .ch_i         (ch_q),
    .old_raddr_o  (old_raddr),
    .old_rdata_i  (old_rdata),
    .text_raddr_o (text_raddr),
    .text_rdata_i (text_rdata),
    .new_we_o     (new_we),
    .new_waddr_o  (new_waddr),
    .new_wdata_o  (new_wdata),
    .count_o      (walk_count),
    .stat_o       (walk_stat)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ch_q <= text_byte_i;
    end
  end

  // Sequencer and result register. The result is loaded in S_FIN as soon
  // as the output register is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pos_q         <= '0;
      len_q         <= '0;
      total_q       <= '0;
      bank_q        <= 1'b0;
      ovf_q         <= 1'b0;
      start_q       <= 1'b0;
      out_valid_o   <= 1'b0;
      total_count_o <= '0;
      ending_here_o <= '0;
      overflow_o    <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            pos_q   <= pos_eff;
            len_q   <= len_eff;
            total_q <= total_eff;
            ovf_q   <= too_long;
            if (too_long) begin
              state_q <= S_FIN;
            end else begin
              start_q <= 1'b1;
              state_q <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (walk_stat.done) begin
            len_q   <= walk_count;
            pos_q   <= pos_q + CW'(1);
            total_q <= total_q + psc_pkg::TOTAL_W'(walk_count);
            bank_q  <= !bank_q;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o   <= 1'b1;
            total_count_o <= total_q;
            ending_here_o <= ovf_q ? '0 : psc_pkg::ENDING_W'(len_q);
            overflow_o    <= ovf_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The walker only runs while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_stat.busy |-> (state_q == S_WALK))
    else $error("list walker busy outside the walk state");

  // The string never holds more than MAX_LEN bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= CW'(MAX_LEN))
    else $error("position beyond MAX_LEN");

  // Palindromes ending at the last byte cannot outnumber the stored bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= pos_q)
    else $error("start list longer than the string");

  // A finished walk holds at least the single-byte palindrome and at most
  // one start per stored byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_stat.done |-> ((walk_count != '0) && (walk_count <= pos_q + CW'(1))))
    else $error("walk count out of range");

  // A stored byte always starts the walker on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !too_long) |=> (start_q && (state_q == S_WALK)))
    else $error("walker not started for a stored byte");
`endif

endmodule
